>>> rtl/core/lpc_pkg.sv
`default_nettype none

package lpc_pkg;

  localparam int unsigned COLOR_COUNT_DEF = 8;
  localparam int unsigned NUM_REGS        = 8;
  localparam int unsigned IDX_W           = 3;
  localparam int unsigned CHAN_W          = 8;
  localparam int unsigned CHANNELS        = 3;
  localparam int unsigned COLOR_W         = CHAN_W * CHANNELS;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned ADDR_W          = 5;
  localparam int unsigned DATA_W          = 32;

  localparam int unsigned HOLD_MS         = 1000;
  localparam int unsigned PERIOD_MS       = 2000;
  localparam int unsigned PERIOD_SHIFT    = 4;
  localparam int unsigned REM_W           = 14;
  localparam int unsigned ELAP_W          = 11;
  localparam int unsigned FADE_W          = 10;
  localparam int unsigned PROD_W          = CHAN_W + FADE_W;

  localparam int unsigned FADE_SHIFT      = 3;
  localparam int unsigned FADE_M_W        = 16;
  localparam logic [FADE_M_W-1:0] FADE_DIV_M = 16'd33555;
  localparam int unsigned FADE_DIV_K      = 22;

  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  nidx;
    logic [FADE_W-1:0] fade;
  } phase_t;

endpackage

`default_nettype wire

>>> rtl/core/led_palette_crossfade_unit.sv
// Channel   Direction  Handshake                       Payload
// in_       input      in_valid / in_stall             in_time_ms
// out_      output     out_valid / out_stall           out_red, out_green, out_blue,
//                                                      out_palette_index
// cfg_      slave      cfg_psel / cfg_penable / pready cfg_paddr, cfg_pwdata, cfg_prdata
//
// One beat is accepted per cycle while in_stall is low.
// Each result passes through six register stages: start offset, period division,
// remainder, phase select, channel multiply and the divide-by-thousand blend.
// Synchronous active-low reset clears the palette, the start time and all valid flags.
// A stalled output holds its beat while empty stages upstream keep filling.
`default_nettype none

module led_palette_crossfade_unit #(
  parameter int unsigned COLOR_COUNT = lpc_pkg::COLOR_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [lpc_pkg::TIME_W-1:0] in_time_ms,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [lpc_pkg::CHAN_W-1:0] out_red,
  output logic      [lpc_pkg::CHAN_W-1:0] out_green,
  output logic      [lpc_pkg::CHAN_W-1:0] out_blue,
  output logic      [lpc_pkg::IDX_W-1:0]  out_palette_index,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [lpc_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [lpc_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [lpc_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import lpc_pkg::*;

  color_t palette [NUM_REGS];
  phase_t ph;
  logic   ph_valid;
  logic   ph_stall;

  lpc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .palette     (palette)
  );

  lpc_phase #(
    .COLOR_COUNT (COLOR_COUNT)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_time_ms (in_time_ms),
    .ph_valid   (ph_valid),
    .ph_stall   (ph_stall),
    .ph         (ph)
  );

  lpc_blend u_blend (
    .clk               (clk),
    .rst_n             (rst_n),
    .ph_valid          (ph_valid),
    .ph_stall          (ph_stall),
    .ph                (ph),
    .palette           (palette),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_palette_index (out_palette_index)
  );

endmodule

`default_nettype wire

>>> rtl/core/lpc_regs.sv
`default_nettype none

module lpc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [lpc_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [lpc_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [lpc_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output lpc_pkg::color_t                 palette [lpc_pkg::NUM_REGS]
);
  import lpc_pkg::*;

  color_t           palette_r [NUM_REGS];
  logic [IDX_W-1:0] reg_sel;
  logic             wr_en;

  assign reg_sel    = cfg_paddr[IDX_W+1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(DATA_W-COLOR_W){1'b0}}, palette_r[reg_sel]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        palette_r[i] <= '0;
      end
    end else if (wr_en) begin
      palette_r[reg_sel] <= cfg_pwdata[COLOR_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      palette[i] = palette_r[i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lpc_phase.sv
`default_nettype none

module lpc_phase #(
  parameter int unsigned COLOR_COUNT = lpc_pkg::COLOR_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [lpc_pkg::TIME_W-1:0] in_time_ms,
  output logic                            ph_valid,
  input  wire logic                       ph_stall,
  output lpc_pkg::phase_t                 ph
);
  import lpc_pkg::*;

  // The full palette cycle is 16 * (odd part) * COLOR_COUNT; the shift takes out the 16.
  localparam int unsigned PER_DIV   = (PERIOD_MS >> PERIOD_SHIFT) * COLOR_COUNT;
  localparam int unsigned X_W       = TIME_W - PERIOD_SHIFT;
  localparam int unsigned M_W       = X_W + 1;
  localparam int unsigned PER_DIV_K = X_W + $clog2(PER_DIV);
  localparam logic [63:0] PER_DIV_M =
    ((64'd1 << PER_DIV_K) + 64'(PER_DIV) - 64'd1) / 64'(PER_DIV);
  localparam int unsigned CYCLE_MS  = PERIOD_MS * COLOR_COUNT;

  logic [TIME_W-1:0]    start_r;
  logic                 started_r;
  logic                 a_valid_r;
  logic [TIME_W-1:0]    a_diff_r;
  logic [TIME_W-1:0]    a_diff_nxt;
  logic                 b_valid_r;
  logic [REM_W-1:0]     b_diff_r;
  logic [REM_W-1:0]     b_quo_r;
  logic [X_W+M_W-1:0]   b_prod;
  logic                 c_valid_r;
  logic [REM_W-1:0]     c_rem_r;
  logic [REM_W-1:0]     c_rem_nxt;
  logic [2*REM_W-1:0]   c_mul;
  logic                 d_valid_r;
  phase_t               d_r;
  phase_t               d_nxt;
  logic [IDX_W-1:0]     d_idx;
  logic [REM_W-1:0]     d_base;
  logic [REM_W-1:0]     d_elap_w;
  logic [ELAP_W-1:0]    d_elap;
  logic [ELAP_W-1:0]    d_fade_w;
  logic                 a_ready;
  logic                 b_ready;
  logic                 c_ready;
  logic                 d_ready;
  logic                 in_take;

  assign d_ready  = !d_valid_r || !ph_stall;
  assign c_ready  = !c_valid_r || d_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_stall = !a_ready;
  assign in_take  = in_valid && a_ready;

  assign a_diff_nxt = started_r ? (in_time_ms - start_r) : '0;

  assign b_prod = a_diff_r[TIME_W-1:PERIOD_SHIFT] * PER_DIV_M[M_W-1:0];

  assign c_mul     = b_quo_r * REM_W'(CYCLE_MS);
  assign c_rem_nxt = b_diff_r - c_mul[REM_W-1:0];

  always_comb begin
    d_idx  = '0;
    d_base = '0;
    for (int k = 1; k < NUM_REGS; k++) begin
      if (k < COLOR_COUNT && c_rem_r >= REM_W'(k * PERIOD_MS)) begin
        d_idx  = IDX_W'(k);
        d_base = REM_W'(k * PERIOD_MS);
      end
    end
    d_elap_w = c_rem_r - d_base;
    d_elap   = d_elap_w[ELAP_W-1:0];
    d_fade_w = d_elap - ELAP_W'(HOLD_MS);
    d_nxt.idx  = d_idx;
    d_nxt.nidx = (d_idx == IDX_W'(COLOR_COUNT - 1)) ? '0 : d_idx + IDX_W'(1);
    d_nxt.fade = (d_elap > ELAP_W'(HOLD_MS)) ? d_fade_w[FADE_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      started_r <= 1'b0;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      if (in_take && !started_r) begin
        start_r   <= in_time_ms;
        started_r <= 1'b1;
      end
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
      if (d_ready) begin
        d_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_diff_r <= a_diff_nxt;
    end
    if (b_ready) begin
      b_diff_r <= a_diff_r[REM_W-1:0];
      b_quo_r  <= b_prod[PER_DIV_K +: REM_W];
    end
    if (c_ready) begin
      c_rem_r <= c_rem_nxt;
    end
    if (d_ready) begin
      d_r <= d_nxt;
    end
  end

  assign ph_valid = d_valid_r;
  assign ph       = d_r;

endmodule

`default_nettype wire

>>> rtl/core/lpc_blend.sv
`default_nettype none

module lpc_blend (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  ph_valid,
  output logic                       ph_stall,
  input  wire lpc_pkg::phase_t       ph,
  input  wire lpc_pkg::color_t       palette [lpc_pkg::NUM_REGS],
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [lpc_pkg::CHAN_W-1:0] out_red,
  output logic [lpc_pkg::CHAN_W-1:0] out_green,
  output logic [lpc_pkg::CHAN_W-1:0] out_blue,
  output logic [lpc_pkg::IDX_W-1:0]  out_palette_index
);
  import lpc_pkg::*;

  localparam int unsigned X_W = PROD_W - FADE_SHIFT;

  color_t                    cur_col;
  color_t                    nxt_col;
  logic [CHAN_W-1:0]         cur_ch   [CHANNELS];
  logic [CHAN_W-1:0]         nxt_ch   [CHANNELS];
  logic [CHAN_W-1:0]         delta    [CHANNELS];
  logic [CHAN_W-1:0]         e_cur_r  [CHANNELS];
  logic                      e_up_r   [CHANNELS];
  logic [PROD_W-1:0]         e_prod_r [CHANNELS];
  logic [PROD_W-1:0]         e_prod_nxt [CHANNELS];
  logic [IDX_W-1:0]          e_idx_r;
  logic                      e_valid_r;
  logic [X_W+FADE_M_W-1:0]   f_quo_w  [CHANNELS];
  logic [CHAN_W-1:0]         f_step   [CHANNELS];
  logic [CHAN_W-1:0]         f_res    [CHANNELS];
  logic [CHAN_W-1:0]         out_ch_r [CHANNELS];
  logic [IDX_W-1:0]          out_idx_r;
  logic                      out_valid_r;
  logic                      e_ready;
  logic                      f_ready;

  assign f_ready  = !out_valid_r || !out_stall;
  assign e_ready  = !e_valid_r || f_ready;
  assign ph_stall = !e_ready;

  assign cur_col = palette[ph.idx];
  assign nxt_col = palette[ph.nidx];

  // Lane 0 is red, lane 1 green, lane 2 blue.
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      cur_ch[i]     = cur_col[COLOR_W-1-i*CHAN_W -: CHAN_W];
      nxt_ch[i]     = nxt_col[COLOR_W-1-i*CHAN_W -: CHAN_W];
      delta[i]      = (nxt_ch[i] > cur_ch[i]) ? (nxt_ch[i] - cur_ch[i])
                                              : (cur_ch[i] - nxt_ch[i]);
      e_prod_nxt[i] = delta[i] * ph.fade;
    end
  end

  // Division by one thousand: drop three bits, then multiply by the reciprocal of 125.
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      f_quo_w[i] = e_prod_r[i][PROD_W-1:FADE_SHIFT] * FADE_DIV_M;
      f_step[i]  = f_quo_w[i][FADE_DIV_K +: CHAN_W];
      f_res[i]   = e_up_r[i] ? (e_cur_r[i] + f_step[i]) : (e_cur_r[i] - f_step[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (e_ready) begin
        e_valid_r <= ph_valid;
      end
      if (f_ready) begin
        out_valid_r <= e_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready) begin
      e_idx_r <= ph.idx;
      for (int i = 0; i < CHANNELS; i++) begin
        e_cur_r[i]  <= cur_ch[i];
        e_up_r[i]   <= nxt_ch[i] > cur_ch[i];
        e_prod_r[i] <= e_prod_nxt[i];
      end
    end
    if (f_ready) begin
      out_idx_r <= e_idx_r;
      for (int i = 0; i < CHANNELS; i++) begin
        out_ch_r[i] <= f_res[i];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_ch_r[0];
  assign out_green         = out_ch_r[1];
  assign out_blue          = out_ch_r[2];
  assign out_palette_index = out_idx_r;

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import lpc_pkg::*;

  localparam logic [TIME_W-1:0] ORIGIN_MS = 32'hFFFF_FA00;
  localparam int unsigned RAMP_MS          = 1000;
  localparam int unsigned REG_STRIDE       = 4;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD        = 400;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned RANDOM_PER_PHASE = 255;
  localparam int unsigned HOLD_PHASE       = 2;

  typedef enum {PAL_ALTERNATE, PAL_RANDOM, PAL_PRIMARIES, PAL_SATURATED, PAL_BLACK} palette_style_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [IDX_W-1:0]  palette_index;
  } pixel_t;

  class crossfade_scoreboard;
    logic [COLOR_W-1:0] palette [NUM_REGS];
    logic [TIME_W-1:0]  origin_ms;
    bit                 origin_set;
    pixel_t             expected_pixels [$];
    int unsigned        errors;

    function new();
      foreach (palette[i]) palette[i] = '0;
      origin_ms  = '0;
      origin_set = 1'b0;
      errors     = 0;
    endfunction

    function void set_palette(int unsigned reg_idx, logic [DATA_W-1:0] value);
      if (reg_idx < NUM_REGS) palette[reg_idx] = value[COLOR_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    function logic [CHAN_W-1:0] fade_channel(logic [CHAN_W-1:0] target,
                                             logic [CHAN_W-1:0] base,
                                             int unsigned ramp_ms);
      int unsigned t_u;
      int unsigned b_u;
      t_u = target;
      b_u = base;
      if (t_u > b_u) return CHAN_W'(b_u + ((t_u - b_u) * ramp_ms) / RAMP_MS);
      if (t_u < b_u) return CHAN_W'(b_u - ((b_u - t_u) * ramp_ms) / RAMP_MS);
      return target;
    endfunction

    function void note_timestamp(logic [TIME_W-1:0] now_ms);
      logic [TIME_W-1:0]  elapsed;
      logic [TIME_W-1:0]  in_period;
      logic [IDX_W-1:0]   base_idx;
      logic [IDX_W-1:0]   next_idx;
      logic [COLOR_W-1:0] cur_c;
      logic [COLOR_W-1:0] nxt_c;
      logic [CHAN_W-1:0]  chan [CHANNELS];
      pixel_t             px;
      if (!origin_set) begin
        origin_ms  = now_ms;
        origin_set = 1'b1;
      end
      elapsed   = now_ms - origin_ms;
      in_period = elapsed % PERIOD_MS;
      base_idx  = IDX_W'((elapsed / PERIOD_MS) % COLOR_COUNT_DEF);
      next_idx  = IDX_W'((base_idx + 1) % COLOR_COUNT_DEF);
      cur_c     = palette[base_idx];
      nxt_c     = palette[next_idx];
      for (int c = 0; c < CHANNELS; c++) begin
        chan[c] = cur_c[CHAN_W*c +: CHAN_W];
        if (in_period > HOLD_MS)
          chan[c] = fade_channel(nxt_c[CHAN_W*c +: CHAN_W], chan[c], in_period - HOLD_MS);
      end
      px.red           = chan[2];
      px.green         = chan[1];
      px.blue          = chan[0];
      px.palette_index = base_idx;
      expected_pixels.push_back(px);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch("beat with nothing expected", got, '0);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red) report_mismatch("red", got.red, want.red);
      if (got.green !== want.green) report_mismatch("green", got.green, want.green);
      if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
      if (got.palette_index !== want.palette_index)
        report_mismatch("palette_index", got.palette_index, want.palette_index);
    endtask
  endclass

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [TIME_W-1:0]   in_time_ms  = '0;
  logic                out_valid;
  logic                out_stall   = 1'b1;
  logic [CHAN_W-1:0]   out_red;
  logic [CHAN_W-1:0]   out_green;
  logic [CHAN_W-1:0]   out_blue;
  logic [IDX_W-1:0]    out_palette_index;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr   = '0;
  logic [DATA_W-1:0]   cfg_pwdata  = '0;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  crossfade_scoreboard sb;
  bit                  src_eager         = 1'b0;
  bit                  sink_eager        = 1'b0;
  int unsigned         sink_hold_cycles  = 0;
  int unsigned         quiet_cycles      = 0;

  logic [TIME_W-1:0] directed_offsets [] = '{
    32'd0, 32'd1, 32'd999, 32'd1000, 32'd1001, 32'd1500, 32'd1999, 32'd2000,
    32'd3001, 32'd3999, 32'd4000, 32'd7500, 32'd15500, 32'd15999, 32'd16000,
    32'hFFFF_FFFF, 32'hFFFF_F830
  };
  logic [TIME_W-1:0] directed_stamps [] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hAAAA_AAAA, 32'h5555_5555
  };
  palette_style_t phase_plan [6] = '{
    PAL_RANDOM, PAL_PRIMARIES, PAL_RANDOM, PAL_SATURATED, PAL_BLACK, PAL_RANDOM
  };

  led_palette_crossfade_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_palette_index (out_palette_index),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    pixel_t seen;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_timestamp(in_time_ms);
      if (out_valid && !out_stall) begin
        seen = '{red: out_red, green: out_green, blue: out_blue,
                 palette_index: out_palette_index};
        sb.check_pixel(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin : result_sink
    int unsigned pause;
    while (!rst_n) @(posedge clk);
    forever begin
      // A long hold lets the pipeline fill up so that the input side stalls.
      if (sink_hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end
      pause = sink_eager ? 0 : $urandom_range(7);
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid || out_stall);
    end
  end

  task automatic send_timestamp(logic [TIME_W-1:0] stamp);
    int unsigned gap;
    gap = src_eager ? 0 : $urandom_range(7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_time_ms <= stamp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic source_idle();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(int unsigned reg_idx, logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(reg_idx * REG_STRIDE);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_palette(reg_idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_palette(palette_style_t style);
    logic [COLOR_W-1:0] primaries [4] = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00};
    logic [COLOR_W-1:0] colour;
    int unsigned        i;
    for (i = 0; i < NUM_REGS; i++) begin
      case (style)
        PAL_ALTERNATE: colour = {COLOR_W{i[0]}};
        PAL_PRIMARIES: colour = primaries[i % 4];
        PAL_SATURATED: colour = '1;
        PAL_BLACK:     colour = '0;
        default:       colour = COLOR_W'($urandom);
      endcase
      cfg_write(i, {(DATA_W-COLOR_W)'($urandom), colour});
    end
  endtask

  function automatic logic [TIME_W-1:0] pick_timestamp();
    logic [TIME_W-1:0] offset;
    if ($urandom_range(9) < 3) return $urandom;
    offset = $urandom_range(63) * PERIOD_MS;
    case ($urandom_range(3))
      0, 1: offset += $urandom_range(PERIOD_MS - 1);
      2:    offset += HOLD_MS - 1 + $urandom_range(3);
      default: begin
        if ($urandom_range(1) == 0) offset += $urandom_range(1);
        else offset += PERIOD_MS - 1 - $urandom_range(1);
      end
    endcase
    return ORIGIN_MS + offset;
  endfunction

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_palette(PAL_ALTERNATE);
    foreach (directed_offsets[k]) send_timestamp(ORIGIN_MS + directed_offsets[k]);
    foreach (directed_stamps[k]) send_timestamp(directed_stamps[k]);
    source_idle();
    wait_drained();

    for (ph = 0; ph < $size(phase_plan); ph++) begin
      program_palette(phase_plan[ph]);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 50 == 0) begin
          src_eager  = ($urandom_range(3) == 0);
          sink_eager = ($urandom_range(3) == 0);
        end
        if (ph == HOLD_PHASE && n == 100) begin
          sink_hold_cycles = LONG_HOLD;
          src_eager        = 1'b1;
        end
        send_timestamp(pick_timestamp());
      end
      source_idle();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lpc_pkg.sv
rtl/core/lpc_regs.sv
rtl/core/lpc_phase.sv
rtl/core/lpc_blend.sv
rtl/core/led_palette_crossfade_unit.sv
bench/tb.sv
